// File: src/vmd_pkg.sv
// Shared types, constants and the quarter-wave sine table of the vibrato delay.
// Used by vmd_ctrl, vmd_datapath and vibrato_modulated_delay; depends on nothing.
package vmd_pkg;

   // Sizing of the delay stores and the sine table.
   localparam int DELAY_LENGTH = 1024;
   localparam int CHANNELS     = 2;
   localparam int SINE_ENTRIES = 256;

   localparam int ADDR_W    = $clog2(DELAY_LENGTH);
   localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int MEM_DEPTH = CHANNELS * DELAY_LENGTH;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);

   // Read positions carry 8 fraction bits and wrap over the whole store span.
   localparam int SPAN  = DELAY_LENGTH * 256;
   localparam int POS_W = $clog2(SPAN);

   // The signed delay is lifted by a multiple of the span so that it is never negative.
   localparam int OFFS   = SPAN * ((65536 + SPAN - 1) / SPAN);
   localparam int DMAX   = 262143 + 65535 + OFFS;
   localparam int DD_W   = $clog2(DMAX + 1);
   localparam int SUM_W  = DD_W + 1;
   localparam int QS     = DD_W + 1;
   localparam longint RECIP = (longint'(1) << QS) / SPAN;
   localparam int RECIP_W = $clog2(RECIP + 1);

   // Sine table addressing.
   localparam int ROM_AW     = $clog2(SINE_ENTRIES);
   localparam int IDX_W      = $clog2(SINE_ENTRIES + 1);
   localparam int QUAD_SPAN  = 32'h0040_0000;
   localparam longint HALF_PI_Q30 = 64'd1686629713;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      REG_BYPASS      = 2'd0,
      REG_PHASE_STEP  = 2'd1,
      REG_BASE_DELAY  = 2'd2,
      REG_DEPTH_SWING = 2'd3
   } reg_index_type;

   typedef logic [14:0] sine_rom_type [SINE_ENTRIES];

   // One step of work that the controller orders from the datapath.
   typedef struct packed {
      logic            load;
      logic            sine;
      logic            delay;
      logic            quot;
      logic            rem;
      logic            write;
      logic            read0;
      logic            read1;
      logic            mix;
      logic            finish;
      logic [CH_W-1:0] ch;
   } vmd_cmd_type;

   typedef struct packed {
      logic       bypass;
      logic [1:0] active;
   } vmd_status_type;

   // Quarter-wave table from a Taylor series in unsigned Q30, rounded to Q15.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  term;
      longint       sum;
      longint       val;
      int           k;
      for (k = 0; k < SINE_ENTRIES; k++) begin
         x    = (64'(k) * HALF_PI_Q30) / SINE_ENTRIES;
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         term = ((term * x2) >> 30) / 6;
         sum  = sum - longint'(term);
         term = ((term * x2) >> 30) / 20;
         sum  = sum + longint'(term);
         term = ((term * x2) >> 30) / 42;
         sum  = sum - longint'(term);
         term = ((term * x2) >> 30) / 72;
         sum  = sum + longint'(term);
         term = ((term * x2) >> 30) / 110;
         sum  = sum - longint'(term);
         if (sum < 0) begin
            sum = 0;
         end
         val = (sum + 16384) >>> 15;
         if (val > 32767) begin
            val = 32767;
         end
         rom[k] = 15'(val);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

// File: src/vmd_ctrl.sv
// Sequencer of the vibrato delay: steps each word through LFO, delay and channel taps.
// Depends on vmd_pkg for the command and status structs.
module vmd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  vmd_pkg::vmd_status_type status,
   output vmd_pkg::vmd_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SINE,
      ST_DELAY,
      ST_QUOT,
      ST_REM,
      ST_WRITE,
      ST_READ0,
      ST_READ1,
      ST_MIX,
      ST_FINISH
   } state_type;

   state_type                 state_ff, state_in;
   logic [vmd_pkg::CH_W-1:0]  ch_ff, ch_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [1:0]                ch_next;
   logic                      out_free;

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign ch_next    = 2'(ch_ff) + 2'd1;

   always_comb begin
      cmd        = '0;
      cmd.ch     = ch_ff;
      cmd.load   = req_tvalid && (state_ff == ST_IDLE);
      cmd.sine   = (state_ff == ST_SINE);
      cmd.delay  = (state_ff == ST_DELAY);
      cmd.quot   = (state_ff == ST_QUOT);
      cmd.rem    = (state_ff == ST_REM);
      cmd.write  = (state_ff == ST_WRITE);
      cmd.read0  = (state_ff == ST_READ0);
      cmd.read1  = (state_ff == ST_READ1);
      cmd.mix    = (state_ff == ST_MIX);
      cmd.finish = (state_ff == ST_FINISH) && out_free;
   end

   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = status.bypass ? ST_FINISH : ST_SINE;
            end
         end
         ST_SINE:  state_in = ST_DELAY;
         ST_DELAY: state_in = ST_QUOT;
         ST_QUOT:  state_in = ST_REM;
         ST_REM: begin
            ch_in    = '0;
            state_in = (status.active == 2'd0) ? ST_FINISH : ST_WRITE;
         end
         ST_WRITE: state_in = ST_READ0;
         ST_READ0: state_in = ST_READ1;
         ST_READ1: state_in = ST_MIX;
         ST_MIX: begin
            if (ch_next < status.active) begin
               ch_in    = ch_ff + 1'b1;
               state_in = ST_WRITE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != ST_IDLE))
      else $error("accepted word did not start processing");

   a_finish_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished word not presented on the result channel");

   a_channel_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> (2'(cmd.ch) < status.active))
      else $error("channel step beyond the active channel count");

   a_stall_holds_finish: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && rsp_valid_ff && !rsp_tready) |=> (state_ff == ST_FINISH))
      else $error("result overwritten while the receiver stalls");

endmodule

// File: src/vmd_datapath.sv
// Datapath of the vibrato delay: registers, LFO, delay reduction, stores and interpolation.
// Depends on vmd_pkg for sizes, the sine table and the command and status structs.
module vmd_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  vmd_pkg::vmd_cmd_type    cmd,
   output vmd_pkg::vmd_status_type status,
   input  logic [31:0]             req_tdata,
   input  logic [1:0]              req_tuser,
   input  logic                    csr_valid,
   input  logic [1:0]              csr_index,
   input  logic [17:0]             csr_data,
   output logic [31:0]             rsp_tdata
);

   localparam int ADDR_W = vmd_pkg::ADDR_W;
   localparam int POS_W  = vmd_pkg::POS_W;
   localparam int DD_W   = vmd_pkg::DD_W;
   localparam int SUM_W  = vmd_pkg::SUM_W;
   localparam int IDX_W  = vmd_pkg::IDX_W;
   localparam int IDXP_W = 23 + IDX_W;
   localparam int QP_W   = DD_W + vmd_pkg::RECIP_W;

   // Configuration registers.
   logic        bypass_ff;
   logic [15:0] phase_step_ff;
   logic [17:0] base_ff;
   logic [15:0] swing_ff;

   // Per-word state.
   logic signed [15:0] smp_ff [2];
   logic signed [15:0] res_ff [2];
   logic [1:0]         active_ff, active_in;
   logic [31:0]        out_ff;
   logic [23:0]        phase_ff;

   // Delay arithmetic.
   logic signed [15:0]  sine_ff, sine_in, sine_mag;
   logic [22:0]         rr;
   logic [IDXP_W-1:0]   idx_prod;
   logic [IDX_W-1:0]    idx;
   logic signed [32:0]  swing_prod;
   logic signed [17:0]  swing_term;
   logic signed [SUM_W-1:0] dsum;
   logic [DD_W-1:0]     dd_ff;
   logic [QP_W-1:0]     qprod;
   logic [DD_W-1:0]     q_ff;
   logic [DD_W-1:0]     rprod, rtmp;
   logic [POS_W-1:0]    dmod_ff, dmod_in;

   // Channel taps.
   logic [ADDR_W-1:0]   wpos_ff [vmd_pkg::CHANNELS];
   logic                full_ff [vmd_pkg::CHANNELS];
   logic [ADDR_W-1:0]   w, i0, i1, ridx;
   logic [POS_W:0]      pw;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic signed [15:0]  mem [vmd_pkg::MEM_DEPTH];
   logic [vmd_pkg::MEM_AW-1:0] waddr, raddr;
   logic signed [15:0]  rd_ff, b0_ff, b1;
   logic                rvalid_ff, rvalid_in;
   logic signed [16:0]  diff;
   logic signed [25:0]  mixp;
   logic signed [17:0]  mix_sum;

   function automatic logic [vmd_pkg::MEM_AW-1:0] mem_addr(
      input logic [vmd_pkg::CH_W-1:0] ch,
      input logic [ADDR_W-1:0]        ix
   );
      return vmd_pkg::MEM_AW'(vmd_pkg::MEM_AW'(ch) * vmd_pkg::MEM_AW'(vmd_pkg::DELAY_LENGTH)
                              + vmd_pkg::MEM_AW'(ix));
   endfunction

   assign status.bypass = bypass_ff;
   assign status.active = active_ff;
   assign rsp_tdata     = out_ff;

   // Sine lookup: quadrant folding and table read.
   always_comb begin
      rr       = phase_ff[22] ? (23'(vmd_pkg::QUAD_SPAN) - {1'b0, phase_ff[21:0]})
                              : {1'b0, phase_ff[21:0]};
      idx_prod = IDXP_W'(rr) * IDXP_W'(vmd_pkg::SINE_ENTRIES);
      idx      = idx_prod[22 +: IDX_W];
      sine_mag = (idx >= IDX_W'(vmd_pkg::SINE_ENTRIES)) ? 16'sh7FFF
               : $signed({1'b0, vmd_pkg::SINE_ROM[idx[vmd_pkg::ROM_AW-1:0]]});
      sine_in  = phase_ff[23] ? -sine_mag : sine_mag;
   end

   // Delay plus a span offset, then its remainder modulo the span by reciprocal.
   always_comb begin
      swing_prod = $signed({1'b0, swing_ff}) * sine_ff;
      swing_term = swing_prod[32:15];
      dsum       = $signed({{(SUM_W-18){1'b0}}, base_ff}) + SUM_W'(swing_term)
                 + SUM_W'(vmd_pkg::OFFS);
      qprod      = QP_W'(dd_ff) * QP_W'(vmd_pkg::RECIP);
      rprod      = q_ff * DD_W'(vmd_pkg::SPAN);
      rtmp       = dd_ff - rprod;
      dmod_in    = (rtmp >= DD_W'(vmd_pkg::SPAN)) ? POS_W'(rtmp - DD_W'(vmd_pkg::SPAN))
                                                 : POS_W'(rtmp);
   end

   // Read position and store addresses of the current channel.
   always_comb begin
      w         = wpos_ff[cmd.ch];
      pw        = {1'b0, w, 8'h00} + (POS_W+1)'(vmd_pkg::SPAN) - {1'b0, dmod_ff};
      pos_in    = (pw >= (POS_W+1)'(vmd_pkg::SPAN)) ? POS_W'(pw - (POS_W+1)'(vmd_pkg::SPAN))
                                                   : POS_W'(pw);
      i0        = pos_ff[POS_W-1:8];
      i1        = (i0 == ADDR_W'(vmd_pkg::DELAY_LENGTH - 1)) ? '0 : i0 + 1'b1;
      ridx      = cmd.read1 ? i1 : i0;
      waddr     = mem_addr(cmd.ch, w);
      raddr     = mem_addr(cmd.ch, ridx);
      // Entries not yet written since reset read as zero.
      rvalid_in = full_ff[cmd.ch] || (ridx < wpos_ff[cmd.ch]);
   end

   // Linear interpolation: b0 + floor((b1 - b0) * f / 256).
   always_comb begin
      b1      = rvalid_ff ? rd_ff : 16'sd0;
      diff    = 17'(b1) - 17'(b0_ff);
      mixp    = diff * $signed({1'b0, pos_ff[7:0]});
      mix_sum = 18'(b0_ff) + mixp[25:8];
   end

   assign active_in = (req_tuser > 2'(vmd_pkg::CHANNELS)) ? 2'(vmd_pkg::CHANNELS) : req_tuser;

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         mem[waddr] <= smp_ff[cmd.ch];
      end
      rd_ff     <= mem[raddr];
      rvalid_ff <= rvalid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff     <= 1'b0;
         phase_step_ff <= 16'd1748;
         base_ff       <= 18'd61440;
         swing_ff      <= 16'd0;
         phase_ff      <= '0;
         for (int c = 0; c < vmd_pkg::CHANNELS; c++) begin
            wpos_ff[c] <= '0;
            full_ff[c] <= 1'b0;
         end
      end else begin
         if (csr_valid) begin
            case (vmd_pkg::reg_index_type'(csr_index))
               vmd_pkg::REG_BYPASS:      bypass_ff     <= csr_data[0];
               vmd_pkg::REG_PHASE_STEP:  phase_step_ff <= csr_data[15:0];
               vmd_pkg::REG_BASE_DELAY:  base_ff       <= csr_data;
               vmd_pkg::REG_DEPTH_SWING: swing_ff      <= csr_data[15:0];
               default: ;
            endcase
         end
         if (cmd.finish && !bypass_ff) begin
            phase_ff <= phase_ff + 24'(phase_step_ff);
         end
         if (cmd.write) begin
            if (w == ADDR_W'(vmd_pkg::DELAY_LENGTH - 1)) begin
               wpos_ff[cmd.ch] <= '0;
               full_ff[cmd.ch] <= 1'b1;
            end else begin
               wpos_ff[cmd.ch] <= w + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         smp_ff[0] <= req_tdata[15:0];
         smp_ff[1] <= req_tdata[31:16];
         res_ff[0] <= req_tdata[15:0];
         res_ff[1] <= req_tdata[31:16];
         active_ff <= active_in;
      end
      if (cmd.sine) begin
         sine_ff <= sine_in;
      end
      if (cmd.delay) begin
         dd_ff <= dsum[DD_W-1:0];
      end
      if (cmd.quot) begin
         q_ff <= DD_W'(qprod >> vmd_pkg::QS);
      end
      if (cmd.rem) begin
         dmod_ff <= dmod_in;
      end
      if (cmd.write) begin
         pos_ff <= pos_in;
      end
      if (cmd.read1) begin
         b0_ff <= rvalid_ff ? rd_ff : 16'sd0;
      end
      if (cmd.mix) begin
         res_ff[cmd.ch] <= mix_sum[15:0];
      end
      if (cmd.finish) begin
         out_ff <= {res_ff[1], res_ff[0]};
      end
   end

endmodule

// File: src/vibrato_modulated_delay.sv
// Top level of the vibrato delay: joins the sequencer and the datapath.
// Depends on vmd_pkg, vmd_ctrl and vmd_datapath.
//
// Usage. Each word on the req_ channel is one stereo frame; req_tuser gives how many
// channels are processed (zero passes both samples through, values above two act as two).
// Each active channel writes its sample into its delay store and reads back at the write
// position minus the modulated delay, interpolated linearly between neighboring entries.
// The rsp_ channel returns exactly one frame for every accepted word, in order.
// The csr_ channel writes bypass, phase step, base delay and depth swing by index; it is
// ready whenever reset is low. It is to be written while the block is idle; the block
// itself does not enforce this.
// A word is accepted only in the idle state. A frame passes the LFO lookup, swing multiply
// and delay reduction, then per active channel a write, two reads and a mix, then the
// hand-over of the result; bypass skips to the hand-over. The result then sits in an
// output register; the next frame is accepted and processed while it waits, and only its
// hand-over stalls until the receiver takes the earlier one.
// Reset returns the configuration to its defaults, the LFO phase and write positions to
// zero, and the stores read as zero until each entry is first written, so no clearing
// pass is needed and the block is ready as soon as reset drops.
module vibrato_modulated_delay (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // left_in [15:0], right_in [31:16]
   input  logic [1:0]  req_tuser,   // channels_used [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // left_out [15:0], right_out [31:16]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [17:0] csr_data
);

   vmd_pkg::vmd_cmd_type    cmd;
   vmd_pkg::vmd_status_type status;

   // Register writes complete in the cycle they are offered.
   assign csr_ready = !reset;

   vmd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   vmd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata)
   );

endmodule
